### hw/rtl/mfcp_pkg.sv
// ----------------------------------------------------------------------------
// mfcp_pkg
// Types and constants shared by the MIDI file chunk parser and its checker.
// ----------------------------------------------------------------------------
package mfcp_pkg;

    localparam logic [31:0] TAG_HEADER = 32'h4D54_6864;   // "MThd"
    localparam logic [31:0] TAG_TRACK  = 32'h4D54_726B;   // "MTrk"
    localparam int unsigned SMPTE_BIT  = 15;
    localparam logic [2:0]  HEADER_LEN = 3'd6;
    localparam logic [15:0] TRACK_MAX  = 16'hFFFF;

    typedef enum logic [3:0] {
        PH_ID   = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_HALT = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_OTHER  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_TRACK  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_TRUNC     = 4'd1,
        ERR_DUP_HDR   = 4'd2,
        ERR_SHORT_HDR = 4'd3,
        ERR_ZERO_DIV  = 4'd4,
        ERR_SMPTE     = 4'd5,
        ERR_BAD_LEN   = 4'd6,
        ERR_NO_HDR    = 4'd7,
        ERR_NO_TRACK  = 4'd8
    } t_err;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0]  track_byte;
        logic        track_byte_valid;
        logic [15:0] track_index;
        logic        chunk_end;
        logic        header_valid;
        logic [15:0] file_format;
        logic [15:0] declared_tracks;
        logic [14:0] ticks_division;
        logic        done_res;
        logic [3:0]  error_code;
    } t_out;

endpackage

### hw/rtl/midi_file_chunk_parser.sv
// ----------------------------------------------------------------------------
// midi_file_chunk_parser
// Splits a Standard MIDI File byte stream into chunks, captures the header,
// passes track payload bytes out and reports the first error.
// ----------------------------------------------------------------------------
// One file byte is taken per cycle unless stalled, giving exactly one result,
// which shows in the output register on the following cycle; a new byte can
// be taken in the same cycle that the previous result is transferred, so the
// sustained rate is one byte per clock. The parser state is updated from the
// input byte in one pass of logic ahead of the result register, and input
// ready drops only while that register holds a result the sink has not
// taken. Errors are sticky until reset; after the last byte all further bytes
// give idle results. Track bytes already delivered are not withdrawn when the
// file later proves truncated, so a nonzero error_code voids the tracks.
module midi_file_chunk_parser
    import mfcp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_phase      r_phase, n_phase;
    logic [1:0]  r_fbc, n_fbc;
    t_kind       r_kind, n_kind;
    logic [30:0] r_rem, n_rem;
    logic [2:0]  r_hbs, n_hbs;
    logic        r_hseen, n_hseen;
    logic [15:0] r_fmt, n_fmt;
    logic [15:0] r_cnt, n_cnt;
    logic [15:0] r_div, n_div;
    logic [15:0] r_total, n_total;
    t_err        r_err, n_err;
    logic [31:0] r_id, n_id;

    logic        r_out_valid;
    t_out        r_out, n_out;

    logic        in_xfer;
    logic        do_close;
    logic [7:0]  b;
    logic [31:0] shifted;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign b       = i_in_data.data_byte;
    assign shifted = {r_id[23:0], b};

    always_comb begin
        n_phase  = r_phase;
        n_fbc    = r_fbc;
        n_kind   = r_kind;
        n_rem    = r_rem;
        n_hbs    = r_hbs;
        n_hseen  = r_hseen;
        n_fmt    = r_fmt;
        n_cnt    = r_cnt;
        n_div    = r_div;
        n_total  = r_total;
        n_err    = r_err;
        n_id     = r_id;
        do_close = 1'b0;
        n_out    = '0;
        n_out.track_index = r_total;

        if (r_err == ERR_NONE && r_phase != PH_HALT) begin
            unique case (r_phase)
                PH_ID: begin
                    n_id  = shifted;
                    n_fbc = r_fbc + 2'd1;
                    if (r_fbc == 2'd3) begin
                        if (shifted == TAG_HEADER) begin
                            n_kind = KIND_HEADER;
                        end else if (shifted == TAG_TRACK) begin
                            n_kind = KIND_TRACK;
                        end else begin
                            n_kind = KIND_OTHER;
                        end
                        n_id    = '0;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_id  = shifted;
                    n_fbc = r_fbc + 2'd1;
                    if (r_fbc == 2'd3) begin
                        if (shifted[31]) begin
                            n_err = ERR_BAD_LEN;
                        end else begin
                            n_rem = shifted[30:0];
                            n_hbs = '0;
                            if (shifted[30:0] == '0) begin
                                do_close = 1'b1;
                            end else begin
                                n_phase = PH_BODY;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    if (r_kind == KIND_HEADER) begin
                        if (r_hbs < HEADER_LEN) begin
                            if (!r_hseen) begin
                                unique case (r_hbs)
                                    3'd0:    n_fmt[15:8] = b;
                                    3'd1:    n_fmt[7:0]  = b;
                                    3'd2:    n_cnt[15:8] = b;
                                    3'd3:    n_cnt[7:0]  = b;
                                    3'd4:    n_div[15:8] = b;
                                    default: n_div[7:0]  = b;
                                endcase
                            end
                            n_hbs = r_hbs + 3'd1;
                        end
                    end else if (r_kind == KIND_TRACK) begin
                        n_out.track_byte       = b;
                        n_out.track_byte_valid = 1'b1;
                    end
                    if (r_rem != '0) begin
                        n_rem = r_rem - 31'd1;
                    end
                    do_close = (r_rem <= 31'd1);
                end
                default: begin
                end
            endcase

            if (do_close) begin
                n_phase = PH_ID;
                n_fbc   = '0;
                n_id    = '0;
                if (r_kind == KIND_HEADER) begin
                    if (r_hseen) begin
                        n_err = ERR_DUP_HDR;
                    end else if (n_hbs < HEADER_LEN) begin
                        n_err = ERR_SHORT_HDR;
                    end else if (n_div == '0) begin
                        n_err = ERR_ZERO_DIV;
                    end else if (n_div[SMPTE_BIT]) begin
                        n_err = ERR_SMPTE;
                    end else begin
                        n_hseen = 1'b1;
                    end
                end else if (r_kind == KIND_TRACK) begin
                    n_out.chunk_end = 1'b1;
                    if (r_total != TRACK_MAX) begin
                        n_total = r_total + 16'd1;
                    end
                end
            end

            if (i_in_data.last_byte) begin
                if (n_err == ERR_NONE) begin
                    if (n_phase != PH_ID || n_fbc != '0) begin
                        n_err = ERR_TRUNC;
                    end else if (!n_hseen) begin
                        n_err = ERR_NO_HDR;
                    end else if (n_total == '0) begin
                        n_err = ERR_NO_TRACK;
                    end else begin
                        n_out.done_res = 1'b1;
                    end
                end
                n_phase = PH_HALT;
            end
        end

        n_out.header_valid    = n_hseen;
        n_out.file_format     = n_fmt;
        n_out.declared_tracks = n_cnt;
        n_out.ticks_division  = n_div[14:0];
        n_out.error_code      = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ID;
            r_fbc       <= '0;
            r_kind      <= KIND_OTHER;
            r_rem       <= '0;
            r_hbs       <= '0;
            r_hseen     <= 1'b0;
            r_fmt       <= '0;
            r_cnt       <= '0;
            r_div       <= '0;
            r_total     <= '0;
            r_err       <= ERR_NONE;
            r_id        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_phase     <= n_phase;
                r_fbc       <= n_fbc;
                r_kind      <= n_kind;
                r_rem       <= n_rem;
                r_hbs       <= n_hbs;
                r_hseen     <= n_hseen;
                r_fmt       <= n_fmt;
                r_cnt       <= n_cnt;
                r_div       <= n_div;
                r_total     <= n_total;
                r_err       <= n_err;
                r_id        <= n_id;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out <= n_out;
        end
    end

endmodule

### hw/rtl/mfcp_checker.sv
// ----------------------------------------------------------------------------
// mfcp_checker
// Port-level assertions for the MIDI file chunk parser, bound to the top.
// ----------------------------------------------------------------------------
module mfcp_checker
    import mfcp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // stalled result transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // no result appears out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a free output slot always takes the next byte
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    // an accepted file has a header and no error
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |->
            o_out_data.error_code == ERR_NONE && o_out_data.header_valid)
        else $error("done reported with error or without header");

    // track output only while parsing, or on a last byte that truncates or finds no header
    a_track_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.track_byte_valid || o_out_data.chunk_end) |->
            o_out_data.error_code == ERR_NONE || o_out_data.error_code == ERR_TRUNC
            || o_out_data.error_code == ERR_NO_HDR)
        else $error("track output after an error");

endmodule

bind midi_file_chunk_parser mfcp_checker u_mfcp_checker (.*);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams one Standard MIDI File image through midi_file_chunk_parser under
// random source gaps and sink stalls. A byte-level model of the chunk parser
// tracks every transfer, and each result record is compared field by field.
// The file shape, its ending and the error it provokes vary with the seed.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import mfcp_pkg::*;

    localparam int HOLD_CYCLES    = 200;
    localparam int RANDOM_BYTES   = 320;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;

    typedef enum {
        SC_DONE, SC_TRUNC, SC_BAD_LEN, SC_DUP_HDR, SC_SHORT_HDR,
        SC_ZERO_DIV, SC_SMPTE, SC_NO_HDR, SC_NO_TRACK
    } t_scenario;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    midi_file_chunk_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parser model state
    t_phase      smf_phase     = PH_ID;
    logic [2:0]  smf_field_cnt = '0;
    t_kind       smf_kind      = KIND_OTHER;
    logic [30:0] smf_remaining = '0;
    logic [2:0]  smf_hdr_cnt   = '0;
    logic        smf_hdr_ok    = 1'b0;
    logic [15:0] smf_format    = '0;
    logic [15:0] smf_ntrks     = '0;
    logic [15:0] smf_division  = '0;
    logic [15:0] smf_tracks    = '0;
    t_err        smf_err       = ERR_NONE;
    logic [31:0] smf_shift     = '0;
    t_out        smf_res;

    t_out       parse_reports_q[$];
    logic [7:0] file_bytes[$];

    int        fail_cnt     = 0;
    int        quiet_cycles = 0;
    int        hold_token   = 0;
    int        hold_seen    = 0;
    int        stall_left   = 0;
    bit        idle_on      = 1'b1;
    bit        tracks_on;
    t_scenario scenario;

    function automatic void close_chunk();
        smf_phase     = PH_ID;
        smf_field_cnt = '0;
        smf_shift     = '0;
        if (smf_kind == KIND_HEADER) begin
            if (smf_hdr_ok) smf_err = ERR_DUP_HDR;
            else if (smf_hdr_cnt < HEADER_LEN) smf_err = ERR_SHORT_HDR;
            else if (smf_division == 16'd0) smf_err = ERR_ZERO_DIV;
            else if (smf_division[SMPTE_BIT]) smf_err = ERR_SMPTE;
            else smf_hdr_ok = 1'b1;
        end else if (smf_kind == KIND_TRACK) begin
            smf_res.chunk_end   = 1'b1;
            smf_res.track_index = smf_tracks;
            if (smf_tracks != TRACK_MAX) smf_tracks++;
        end
    endfunction

    function automatic void parse_smf_byte(input t_in item);
        logic [7:0] b;
        b = item.data_byte;
        smf_res = '0;
        smf_res.track_index = smf_tracks;
        if (smf_err == ERR_NONE && smf_phase != PH_HALT) begin
            case (smf_phase)
                PH_ID, PH_LEN: begin
                    smf_shift = {smf_shift[23:0], b};
                    smf_field_cnt++;
                    if (smf_field_cnt == 3'd4) begin
                        smf_field_cnt = '0;
                        if (smf_phase == PH_ID) begin
                            if (smf_shift == TAG_HEADER) smf_kind = KIND_HEADER;
                            else if (smf_shift == TAG_TRACK) smf_kind = KIND_TRACK;
                            else smf_kind = KIND_OTHER;
                            smf_shift = '0;
                            smf_phase = PH_LEN;
                        end else if (smf_shift[31]) begin
                            smf_err = ERR_BAD_LEN;
                        end else begin
                            smf_remaining = smf_shift[30:0];
                            smf_hdr_cnt   = '0;
                            if (smf_remaining == 0) close_chunk();
                            else smf_phase = PH_BODY;
                        end
                    end
                end
                default: begin
                    if (smf_kind == KIND_HEADER) begin
                        if (smf_hdr_cnt < HEADER_LEN) begin
                            if (!smf_hdr_ok) begin
                                case (smf_hdr_cnt)
                                    3'd0: smf_format[15:8]  = b;
                                    3'd1: smf_format[7:0]   = b;
                                    3'd2: smf_ntrks[15:8]   = b;
                                    3'd3: smf_ntrks[7:0]    = b;
                                    3'd4: smf_division[15:8] = b;
                                    default: smf_division[7:0] = b;
                                endcase
                            end
                            smf_hdr_cnt++;
                        end
                    end else if (smf_kind == KIND_TRACK) begin
                        smf_res.track_byte       = b;
                        smf_res.track_byte_valid = 1'b1;
                    end
                    if (smf_remaining != 0) smf_remaining--;
                    if (smf_remaining == 0) close_chunk();
                end
            endcase
            if (item.last_byte) begin
                if (smf_err == ERR_NONE) begin
                    if (smf_phase != PH_ID || smf_field_cnt != 0) smf_err = ERR_TRUNC;
                    else if (!smf_hdr_ok) smf_err = ERR_NO_HDR;
                    else if (smf_tracks == 0) smf_err = ERR_NO_TRACK;
                    else smf_res.done_res = 1'b1;
                end
                smf_phase = PH_HALT;
            end
        end
        smf_res.header_valid    = smf_hdr_ok;
        smf_res.file_format     = smf_format;
        smf_res.declared_tracks = smf_ntrks;
        smf_res.ticks_division  = smf_division[14:0];
        smf_res.error_code      = smf_err;
        parse_reports_q.push_back(smf_res);
    endfunction

    // sink side: random stall bursts, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen   <= hold_token;
            stall_left  <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left  <= $urandom_range(0, 8);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            fail_cnt++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_reports
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (parse_reports_q.size() == 0) begin
                fail_cnt++;
                $error("result transfer with nothing pending: %h", o_out_data);
            end else begin
                want = parse_reports_q.pop_front();
                compare_field("track_byte", 16'(want.track_byte),
                              16'(o_out_data.track_byte));
                compare_field("track_byte_valid", 16'(want.track_byte_valid),
                              16'(o_out_data.track_byte_valid));
                compare_field("track_index", want.track_index, o_out_data.track_index);
                compare_field("chunk_end", 16'(want.chunk_end),
                              16'(o_out_data.chunk_end));
                compare_field("header_valid", 16'(want.header_valid),
                              16'(o_out_data.header_valid));
                compare_field("file_format", want.file_format, o_out_data.file_format);
                compare_field("declared_tracks", want.declared_tracks,
                              o_out_data.declared_tracks);
                compare_field("ticks_division", 16'(want.ticks_division),
                              16'(o_out_data.ticks_division));
                compare_field("done_res", 16'(want.done_res),
                              16'(o_out_data.done_res));
                compare_field("error_code", 16'(want.error_code),
                              16'(o_out_data.error_code));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in item;
        int  gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item.data_byte = b;
        item.last_byte = last;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        parse_smf_byte(item);
    endtask

    task automatic flush(input bit end_file);
        logic [7:0] b;
        while (file_bytes.size() > 0) begin
            b = file_bytes.pop_front();
            send_byte(b, end_file && file_bytes.size() == 0);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (parse_reports_q.size() != 0);
    endtask

    function automatic void add_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) file_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void add_chunk(input logic [31:0] id, input logic [31:0] len,
                                      input int nbody);
        add_word(id);
        add_word(len);
        repeat (nbody) file_bytes.push_back(8'($urandom));
    endfunction

    function automatic void add_header(input logic [31:0] len, input logic [15:0] fmt,
                                       input logic [15:0] ntrk, input logic [15:0] div);
        logic [47:0] words;
        words = {fmt, ntrk, div};
        add_word(TAG_HEADER);
        add_word(len);
        for (int i = 0; i < len; i++) begin
            if (i < 6) file_bytes.push_back(words[47 - 8*i -: 8]);
            else file_bytes.push_back(8'($urandom));
        end
    endfunction

    function automatic logic [15:0] good_division();
        case ($urandom_range(0, 2))
            0: good_division = 16'h7FFF;
            1: good_division = 16'h0001;
            default: good_division = {1'b0, 15'($urandom)} | 16'h0001;
        endcase
    endfunction

    task automatic test_prelude();
        if (tracks_on) begin
            add_chunk(TAG_TRACK, 0, 0);
            add_chunk(TAG_TRACK, 2, 0);
        end else begin
            add_chunk(TAG_TRACK ^ 32'h1, 2, 0);
        end
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        flush(1'b0);
    endtask

    task automatic test_header();
        // seven bytes: the one past the division must be ignored
        add_header(7, 16'hFFFF, 16'($urandom), good_division());
        flush(1'b0);
    endtask

    task automatic test_backpressure();
        hold_token++;
        add_chunk(tracks_on ? TAG_TRACK : 32'h4D54_6578, 40, 40);
        flush(1'b0);
        wait_drained();
    endtask

    task automatic test_random_chunks();
        int          sent;
        int          len;
        logic [31:0] id;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) len = $urandom_range(17, 64);
            else len = $urandom_range(0, 16);
            case ($urandom_range(0, 5))
                0: id = $urandom;
                1: id = TAG_HEADER ^ (32'd1 << $urandom_range(0, 31));
                2: id = TAG_TRACK ^ (32'd1 << $urandom_range(0, 31));
                default: id = TAG_TRACK;
            endcase
            if (!tracks_on && id == TAG_TRACK) id = ~id;
            add_chunk(id, len, len);
            sent += 8 + len;
            flush(1'b0);
        end
        idle_on = 1'b1;
    endtask

    // empty and short track chunks back to back (when tracks are on), no gaps from here on
    task automatic test_back_to_back();
        idle_on = 1'b0;
        if (tracks_on) begin
            repeat (3) add_chunk(TAG_TRACK, 0, 0);
            add_chunk(TAG_TRACK, 3, 3);
            flush(1'b0);
        end
    endtask

    task automatic test_file_end();
        int keep;
        case (scenario)
            SC_TRUNC: begin
                add_chunk(TAG_TRACK, 32'h7FFF_FFFF, 6);
                case ($urandom_range(0, 2))
                    0: keep = $urandom_range(1, 3);
                    1: keep = $urandom_range(5, 7);
                    default: keep = $urandom_range(9, 14);
                endcase
                while (file_bytes.size() > keep) void'(file_bytes.pop_back());
                flush(1'b1);
            end
            SC_BAD_LEN: begin
                add_word($urandom_range(0, 1) ? TAG_TRACK : 32'h5845_5846);
                add_word(32'h8000_0000 | $urandom);
                flush(1'b0);
            end
            SC_DUP_HDR: begin
                add_header($urandom_range(6, 8), 16'($urandom), 16'($urandom),
                           good_division());
                flush(1'b0);
            end
            SC_SHORT_HDR: begin
                add_header($urandom_range(0, 5), 16'($urandom), 16'($urandom),
                           good_division());
                flush(1'b0);
            end
            SC_ZERO_DIV: begin
                add_header(6, 16'($urandom), 16'($urandom), 16'h0000);
                flush(1'b0);
            end
            SC_SMPTE: begin
                add_header(6, 16'($urandom), 16'($urandom), 16'h8000 | 16'($urandom));
                flush(1'b0);
            end
            default: begin
                case (tracks_on ? $urandom_range(0, 2) : 2)
                    0: begin
                        keep = $urandom_range(1, 8);
                        add_chunk(TAG_TRACK, keep, keep);
                    end
                    1: add_chunk(TAG_TRACK, 0, 0);
                    default: begin
                        keep = $urandom_range(0, 8);
                        add_chunk($urandom_range(0, 1) ? 32'h4D54_6B72 : $urandom, keep, keep);
                    end
                endcase
                flush(1'b1);
            end
        endcase
    endtask

    // everything past the end or past an error must come back idle
    task automatic test_after_end();
        repeat (6) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5: scenario = SC_DONE;
            6, 7, 15:         scenario = SC_TRUNC;
            8:                scenario = SC_BAD_LEN;
            9:                scenario = SC_DUP_HDR;
            10:               scenario = SC_SHORT_HDR;
            11:               scenario = SC_ZERO_DIV;
            12:               scenario = SC_SMPTE;
            13:               scenario = SC_NO_HDR;
            default:          scenario = SC_NO_TRACK;
        endcase
        tracks_on = (scenario != SC_NO_TRACK);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_prelude();
        if (scenario inside {SC_DONE, SC_TRUNC, SC_BAD_LEN, SC_DUP_HDR, SC_NO_TRACK})
            test_header();
        test_backpressure();
        test_random_chunks();
        test_back_to_back();
        test_file_end();
        test_after_end();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

### midi_file_chunk_parser.f
hw/rtl/mfcp_pkg.sv
hw/rtl/midi_file_chunk_parser.sv
hw/rtl/mfcp_checker.sv
tb/tb_top.sv
